FILE: rtl/core/seinf_pkg.sv
// seinf_pkg: types, constants and control-store program for the SEI NAL framer.
// No dependencies.
package seinf_pkg;

    localparam int unsigned MAX_PAYLOAD = 4095;
    localparam int          PC_W        = 5;
    localparam int          SIZE_W      = 13;

    localparam logic [11:0] LEN_CAP = (MAX_PAYLOAD > 4095) ? 12'd4095 : 12'(MAX_PAYLOAD);

    localparam logic [7:0] SEI_NAL_TYPE_HEVC = 8'd39;
    localparam logic [7:0] HEVC_HDR0   = 8'(SEI_NAL_TYPE_HEVC << 1);
    localparam logic [7:0] AVC_HDR     = 8'h06;
    localparam logic [7:0] SEI_PT_UDU  = 8'h05;
    localparam logic [7:0] SIZE_RUN    = 8'hFF;
    localparam logic [7:0] TRAILER     = 8'h80;
    localparam logic [7:0] EP_BYTE     = 8'h03;
    localparam logic [1:0] ZR_SAT      = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_BASE = 13'd16;
    localparam logic [SIZE_W-1:0] SIZE_STEP = 13'd255;

    localparam logic [PC_W-1:0] STEP_ENTRY = 5'd0;
    localparam logic [PC_W-1:0] STEP_DATA  = 5'd24;

    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_HDR,
        SRC_SIZE,
        SRC_DATA
    } src_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_HEVC,
        COND_SIZE,
        COND_DATA,
        COND_LAST,
        COND_NEVER
    } cond_t;

    typedef struct packed {
        logic [7:0] lit;
        src_t       src;
        cond_t      cond;
        logic       rbsp;
        logic       eou;
        logic       fin;
    } ctl_t;

    function automatic ctl_t step_word(input logic [7:0] lit, input src_t src,
                                       input cond_t cond, input logic rbsp,
                                       input logic eou, input logic fin);
        ctl_t c;
        c.lit  = lit;
        c.src  = src;
        c.cond = cond;
        c.rbsp = rbsp;
        c.eou  = eou;
        c.fin  = fin;
        return c;
    endfunction

    // control store
    function automatic ctl_t seinf_rom(input logic [PC_W-1:0] pc);
        ctl_t c;
        unique case (pc)
            5'd0:  c = step_word(8'h00, SRC_LIT, COND_ALWAYS, 1'b0, 1'b0, 1'b0);
            5'd1:  c = step_word(8'h00, SRC_LIT, COND_ALWAYS, 1'b0, 1'b0, 1'b0);
            5'd2:  c = step_word(8'h00, SRC_LIT, COND_ALWAYS, 1'b0, 1'b0, 1'b0);
            5'd3:  c = step_word(8'h01, SRC_LIT, COND_ALWAYS, 1'b0, 1'b0, 1'b0);
            5'd4:  c = step_word(AVC_HDR, SRC_HDR, COND_ALWAYS, 1'b0, 1'b0, 1'b0);
            5'd5:  c = step_word(8'h01, SRC_LIT, COND_HEVC, 1'b0, 1'b0, 1'b0);
            5'd6:  c = step_word(SEI_PT_UDU, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd7:  c = step_word(SIZE_RUN, SRC_SIZE, COND_SIZE, 1'b1, 1'b0, 1'b0);
            5'd8:  c = step_word(8'ha1, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd9:  c = step_word(8'hb2, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd10: c = step_word(8'hc3, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd11: c = step_word(8'hd4, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd12: c = step_word(8'he5, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd13: c = step_word(8'hf6, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd14: c = step_word(8'h47, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd15: c = step_word(8'h80, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd16: c = step_word(8'hab, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd17: c = step_word(8'hcd, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd18: c = step_word(8'hef, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd19: c = step_word(8'h12, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd20: c = step_word(8'h34, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd21: c = step_word(8'h56, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd22: c = step_word(8'h78, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd23: c = step_word(8'h90, SRC_LIT, COND_ALWAYS, 1'b1, 1'b0, 1'b0);
            5'd24: c = step_word(8'h00, SRC_DATA, COND_DATA, 1'b1, 1'b0, 1'b0);
            5'd25: c = step_word(TRAILER, SRC_LIT, COND_LAST, 1'b1, 1'b1, 1'b1);
            default: c = step_word(8'h00, SRC_LIT, COND_NEVER, 1'b0, 1'b0, 1'b1);
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/seinf_if.sv
// seinf_in_if / seinf_out_if: valid/ready channels for payload words and NAL words.
// No dependencies.
interface seinf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [11:0] message_length;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, output message_length, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input last_byte, input message_length, output ready);
endinterface

interface seinf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_unit;

    modport source (output valid, output out_byte, output end_of_unit, input ready);
    modport sink   (input valid, input out_byte, input end_of_unit, output ready);
endinterface

FILE: rtl/core/seinf_seq.sv
// seinf_seq: step counter over the control store, issues one control word per step.
// Depends on seinf_pkg.
module seinf_seq
    import seinf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [PC_W-1:0] start_pc,
    input  logic            step_done,
    output logic            busy,
    output ctl_t            ctl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            busy_reg;
    logic            busy_next;

    assign ctl  = seinf_rom(pc_reg);
    assign busy = busy_reg;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = start_pc;
            busy_next = 1'b1;
        end
        else if (busy_reg && step_done)
        begin
            if (ctl.fin)
                busy_next = 1'b0;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= STEP_ENTRY;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

FILE: rtl/core/sei_user_data_nal_framer.sv
// sei_user_data_nal_framer: top level, input capture, byte datapath, output register.
// Depends on seinf_pkg, seinf_if, seinf_seq.

// Frames each user-data message as an Annex B SEI NAL unit. A first word runs
// 6 steps of start code and header (the second header step idles in H.264
// mode), 1 of payload type, a size step of 1 to 17 bytes, 16 of UUID, then a
// data step and a trailer step; a step whose condition fails emits nothing.
// Each later word runs the data step and the trailer step, with a 0x03 going
// in before its data byte where the zero run calls for it. The microcoded
// sequencer emits at most one output word per cycle and holds the input while
// it runs; a full output register with ready low stalls it.
module sei_user_data_nal_framer
    import seinf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    seinf_in_if.sink    byte_in,
    seinf_out_if.source nal_out
);

    logic       hevc_reg;
    logic       in_msg_reg;
    logic       in_msg_next;
    logic [1:0] zero_run_reg;
    logic [1:0] zero_run_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       emit_data_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       eou_reg;
    logic       eou_next;

    logic            busy;
    ctl_t            ctl;
    logic            accept;
    logic            start;
    logic [PC_W-1:0] start_pc;
    logic            step_done;
    logic [11:0]     len_cap;
    logic [11:0]     len_eff;
    logic            cond_ok;
    logic            size_big;
    logic [7:0]      byte_sel;
    logic            ep;
    logic            slot_free;
    logic            emit;

    seinf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .start_pc  (start_pc),
        .step_done (step_done),
        .busy      (busy),
        .ctl       (ctl)
    );

    assign byte_in.ready = !busy;
    assign accept   = byte_in.valid && !busy;
    assign start    = accept && (byte_in.first_byte || in_msg_reg);
    assign start_pc = byte_in.first_byte ? STEP_ENTRY : STEP_DATA;

    assign len_cap = (byte_in.message_length > LEN_CAP) ? LEN_CAP : byte_in.message_length;
    assign len_eff = (byte_in.last_byte && len_cap > 12'd1) ? 12'd1 : len_cap;

    assign size_big = size_reg >= SIZE_STEP;

    always_comb
    begin
        case (ctl.cond)
            COND_ALWAYS: cond_ok = 1'b1;
            COND_HEVC:   cond_ok = hevc_reg;
            COND_SIZE:   cond_ok = 1'b1;
            COND_DATA:   cond_ok = emit_data_reg;
            COND_LAST:   cond_ok = last_reg;
            default:     cond_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        case (ctl.src)
            SRC_LIT:  byte_sel = ctl.lit;
            SRC_HDR:  byte_sel = hevc_reg ? HEVC_HDR0 : ctl.lit;
            SRC_SIZE: byte_sel = size_big ? SIZE_RUN : size_reg[7:0];
            default:  byte_sel = data_reg;
        endcase
    end

    assign ep        = ctl.rbsp && (zero_run_reg == ZR_SAT) && (byte_sel <= EP_BYTE);
    assign slot_free = !out_valid_reg || nal_out.ready;
    assign emit      = busy && cond_ok && slot_free;
    assign step_done = busy && (!cond_ok ||
                       (emit && !ep && !(ctl.cond == COND_SIZE && size_big)));

    always_comb
    begin
        in_msg_next    = in_msg_reg;
        zero_run_next  = zero_run_reg;
        size_next      = size_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        eou_next       = eou_reg;

        if (accept)
            in_msg_next = byte_in.first_byte ? !byte_in.last_byte
                                             : (in_msg_reg && !byte_in.last_byte);

        if (accept && byte_in.first_byte)
        begin
            zero_run_next = 2'd0;
            size_next     = SIZE_BASE + {1'b0, len_eff};
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = ep ? EP_BYTE : byte_sel;
            eou_next       = ep ? 1'b0 : ctl.eou;
            if (ctl.rbsp)
            begin
                if (ep)
                    zero_run_next = 2'd0;
                else if (byte_sel == 8'h00)
                    zero_run_next = (zero_run_reg == ZR_SAT) ? ZR_SAT : zero_run_reg + 2'd1;
                else
                    zero_run_next = 2'd0;
            end
            if (ctl.src == SRC_SIZE && !ep && size_big)
                size_next = size_reg - SIZE_STEP;
        end
        else if (nal_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hevc_reg      <= 1'b0;
            in_msg_reg    <= 1'b0;
            zero_run_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                hevc_reg <= cfg_wdata;
            in_msg_reg    <= in_msg_next;
            zero_run_reg  <= zero_run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg     <= size_next;
        out_byte_reg <= out_byte_next;
        eou_reg      <= eou_next;
        if (accept)
        begin
            data_reg      <= byte_in.data_byte;
            last_reg      <= byte_in.last_byte;
            emit_data_reg <= !byte_in.first_byte || (len_eff != 12'd0);
        end
    end

    assign nal_out.valid       = out_valid_reg;
    assign nal_out.out_byte    = out_byte_reg;
    assign nal_out.end_of_unit = eou_reg;

`ifndef NO_ASSERTIONS
    a_zero_run_range: assert property (@(posedge clk) disable iff (!rst_n)
        zero_run_reg != 2'd3)
        else $error("zero run out of range");

    a_eou_is_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        (nal_out.valid && nal_out.end_of_unit) |-> nal_out.out_byte == TRAILER)
        else $error("end of unit on a byte other than the trailer");

    a_first_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_in.first_byte) |=> (busy && !byte_in.ready))
        else $error("first word did not start the sequencer");

    a_ep_holds_step: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && ep) |=> (busy && zero_run_reg == 2'd0))
        else $error("emulation byte ended the step");
`endif

endmodule

FILE: dv/tb_sei_user_data_nal_framer.sv
`timescale 1ns / 100ps
// tb_sei_user_data_nal_framer: self-checking testbench for the SEI user-data NAL framer.
// Directed table, then random messages in several header modes, checked word by word.
// Depends on seinf_pkg, seinf_if and sei_user_data_nal_framer.
module tb_sei_user_data_nal_framer;

    localparam logic [7:0] AVC_SEI_HDR   = 8'h06;
    localparam logic [7:0] HEVC_SEI_HDR0 = 8'h4E;
    localparam logic [7:0] HEVC_SEI_HDR1 = 8'h01;
    localparam logic [7:0] PT_USER_DATA  = 8'h05;
    localparam logic [7:0] SIZE_FF       = 8'hFF;
    localparam logic [7:0] RBSP_TRAILER  = 8'h80;
    localparam logic [7:0] EMU_PREVENT   = 8'h03;
    localparam logic [1:0] ZERO_SAT      = 2'd2;
    localparam int         UUID_LEN      = 16;
    localparam logic [7:0] NRES_ANY      = 8'hFF;
    localparam int         TAIL_CYCLES   = 60;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         ITEMS_PER_PH  = 30;

    localparam logic [7:0] UUID_BYTES [UUID_LEN] = '{
        8'ha1, 8'hb2, 8'hc3, 8'hd4, 8'he5, 8'hf6, 8'h47, 8'h80,
        8'hab, 8'hcd, 8'hef, 8'h12, 8'h34, 8'h56, 8'h78, 8'h90
    };

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [11:0] len;
    } pay_word_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eou;
    } nal_word_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [11:0] len;
        logic        hevc;
        logic [7:0]  nres;
    } dir_row_t;

    // data, first, last, length, hevc, result count (NRES_ANY: predictor only)
    dir_row_t dir_tab [25] = '{
        '{8'h42, 1'b0, 1'b0, 12'd5,    1'b0, 8'd0},
        '{8'h42, 1'b1, 1'b1, 12'd1,    1'b0, 8'd25},
        '{8'h00, 1'b1, 1'b1, 12'd0,    1'b0, 8'd24},
        '{8'hFF, 1'b1, 1'b1, 12'd4095, 1'b0, 8'd25},
        '{8'h00, 1'b1, 1'b0, 12'd4095, 1'b0, 8'd40},
        '{8'h00, 1'b0, 1'b0, 12'd0,    1'b0, NRES_ANY},
        '{8'h01, 1'b0, 1'b0, 12'd0,    1'b0, NRES_ANY},
        '{8'h00, 1'b0, 1'b0, 12'd0,    1'b0, NRES_ANY},
        '{8'h00, 1'b0, 1'b0, 12'd0,    1'b0, NRES_ANY},
        '{8'h03, 1'b0, 1'b0, 12'd0,    1'b0, NRES_ANY},
        '{8'h00, 1'b0, 1'b0, 12'd0,    1'b0, NRES_ANY},
        '{8'h00, 1'b0, 1'b0, 12'd0,    1'b0, NRES_ANY},
        '{8'h04, 1'b0, 1'b0, 12'd0,    1'b0, NRES_ANY},
        '{8'h55, 1'b1, 1'b0, 12'd239,  1'b0, NRES_ANY},
        '{8'h00, 1'b0, 1'b0, 12'd0,    1'b0, NRES_ANY},
        '{8'h00, 1'b0, 1'b1, 12'd0,    1'b0, NRES_ANY},
        '{8'h7E, 1'b1, 1'b1, 12'd1,    1'b1, 8'd26},
        '{8'h00, 1'b1, 1'b1, 12'd0,    1'b1, 8'd25},
        '{8'h10, 1'b1, 1'b0, 12'd0,    1'b1, NRES_ANY},
        '{8'hAA, 1'b0, 1'b0, 12'd4095, 1'b1, NRES_ANY},
        '{8'h00, 1'b0, 1'b1, 12'd0,    1'b1, NRES_ANY},
        '{8'h00, 1'b1, 1'b0, 12'd4095, 1'b1, 8'd41},
        '{8'h00, 1'b0, 1'b0, 12'd0,    1'b1, NRES_ANY},
        '{8'h02, 1'b0, 1'b1, 12'd0,    1'b1, NRES_ANY},
        '{8'h33, 1'b0, 1'b1, 12'd0,    1'b1, 8'd0}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    seinf_in_if  byte_in ();
    seinf_out_if nal_out ();

    sei_user_data_nal_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .byte_in   (byte_in),
        .nal_out   (nal_out)
    );

    // predictor state
    logic [1:0] zrun_pred;
    logic       msg_open;
    logic       hevc_sel;
    nal_word_t  nal_expect [$];

    nal_word_t  exp_w;
    int         fail_cnt;
    int         words_in;
    int         words_out;
    int         msgs_sent;
    int         cfg_writes;
    int         idle_cycles;
    bit         no_gaps;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic void emit_raw(input logic [7:0] b, input logic eou);
        nal_word_t w;
        w.b   = b;
        w.eou = eou;
        nal_expect = {nal_expect, w};
    endfunction

    function automatic void emit_rbsp(input logic [7:0] b, input logic eou);
        if (zrun_pred == ZERO_SAT && b <= EMU_PREVENT)
        begin
            emit_raw(EMU_PREVENT, 1'b0);
            zrun_pred = 2'd0;
        end
        emit_raw(b, eou);
        if (b == 8'h00)
        begin
            if (zrun_pred < ZERO_SAT)
                zrun_pred = zrun_pred + 2'd1;
        end
        else
            zrun_pred = 2'd0;
    endfunction

    // Appends the NAL words one payload word causes; returns how many.
    function automatic int frame_word(input pay_word_t w);
        int          n0;
        int          size;
        logic [11:0] len;
        bit          keep_data;
        n0 = nal_expect.size();
        keep_data = 1'b1;
        if (w.first)
        begin
            len = w.len;
            if (w.last && len > 12'd1)
                len = 12'd1;
            if (len == 12'd0)
                keep_data = 1'b0;
            emit_raw(8'h00, 1'b0);
            emit_raw(8'h00, 1'b0);
            emit_raw(8'h00, 1'b0);
            emit_raw(8'h01, 1'b0);
            if (hevc_sel)
            begin
                emit_raw(HEVC_SEI_HDR0, 1'b0);
                emit_raw(HEVC_SEI_HDR1, 1'b0);
            end
            else
                emit_raw(AVC_SEI_HDR, 1'b0);
            zrun_pred = 2'd0;
            msg_open = 1'b1;
            emit_rbsp(PT_USER_DATA, 1'b0);
            size = UUID_LEN + int'(len);
            while (size >= 255)
            begin
                emit_rbsp(SIZE_FF, 1'b0);
                size -= 255;
            end
            emit_rbsp(8'(size), 1'b0);
            for (int i = 0; i < UUID_LEN; i++)
                emit_rbsp(UUID_BYTES[i], 1'b0);
        end
        else if (!msg_open)
            return 0;
        if (keep_data)
            emit_rbsp(w.data, 1'b0);
        if (w.last)
        begin
            emit_rbsp(RBSP_TRAILER, 1'b1);
            msg_open = 1'b0;
            zrun_pred = 2'd0;
        end
        return nal_expect.size() - n0;
    endfunction

    function automatic logic [7:0] rand_payload();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'h00;
        else if (r < 6)
            return 8'($urandom_range(1, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic put_word(input pay_word_t w, output int n);
        if (!no_gaps)
        begin
            while ($urandom_range(0, 99) < 36)
            begin
                byte_in.valid <= 1'b0;
                @(posedge clk);
            end
        end
        byte_in.valid          <= 1'b1;
        byte_in.data_byte      <= w.data;
        byte_in.first_byte     <= w.first;
        byte_in.last_byte      <= w.last;
        byte_in.message_length <= w.len;
        do
            @(posedge clk);
        while (!byte_in.ready);
        n = frame_word(w);
        words_in++;
    endtask

    task automatic drain();
        byte_in.valid <= 1'b0;
        while (nal_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_hevc(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        hevc_sel   = v;
        cfg_writes++;
    endtask

    task automatic send_message(inout int ph_items);
        pay_word_t w;
        int        len;
        int        cnt;
        int        n;
        int        r;
        bit        drop_last;
        if (!msg_open && $urandom_range(0, 9) == 0)
        begin
            w.data  = rand_payload();
            w.first = 1'b0;
            w.last  = 1'($urandom_range(0, 1));
            w.len   = 12'($urandom_range(0, 4095));
            put_word(w, n);
        end
        r = $urandom_range(0, 9);
        if (r == 0)
            len = $urandom_range(256, 4095);
        else if (r == 1)
            len = 0;
        else
            len = $urandom_range(1, 12);
        if (len == 0)
            cnt = $urandom_range(1, 2);
        else
            cnt = (len < 10) ? len : 10;
        if ($urandom_range(0, 4) == 0)
            cnt = $urandom_range(1, 12);
        drop_last = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < cnt; i++)
        begin
            w.data  = rand_payload();
            w.first = (i == 0);
            w.last  = (i == cnt - 1) && !drop_last;
            w.len   = (i == 0) ? 12'(len) : 12'($urandom_range(0, 4095));
            put_word(w, n);
            ph_items++;
        end
        msgs_sent++;
    endtask

    // receiver
    always @(posedge clk)
    begin
        nal_out.ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 36);
    end

    // output checker
    always @(posedge clk)
    begin
        if (rst_n && nal_out.valid && nal_out.ready)
        begin
            if (nal_expect.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected word: expected none, actual byte %02h eou %0b",
                         $time, nal_out.out_byte, nal_out.end_of_unit);
            end
            else
            begin
                exp_w = nal_expect.pop_front();
                words_out++;
                if (nal_out.out_byte !== exp_w.b)
                begin
                    fail_cnt++;
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, exp_w.b, nal_out.out_byte);
                end
                if (nal_out.end_of_unit !== exp_w.eou)
                begin
                    fail_cnt++;
                    $display("%0t: end_of_unit mismatch: expected %0b, actual %0b",
                             $time, exp_w.eou, nal_out.end_of_unit);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((byte_in.valid && byte_in.ready) || (nal_out.valid && nal_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d words still expected",
                     $time, STALL_LIMIT, nal_expect.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int ph_items;
        int n;
        pay_word_t w;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = 1'b0;
        byte_in.valid          = 1'b0;
        byte_in.data_byte      = 8'h00;
        byte_in.first_byte     = 1'b0;
        byte_in.last_byte      = 1'b0;
        byte_in.message_length = 12'd0;
        nal_out.ready          = 1'b0;
        zrun_pred              = 2'd0;
        msg_open               = 1'b0;
        hevc_sel               = 1'b0;
        fail_cnt               = 0;
        words_in               = 0;
        words_out              = 0;
        msgs_sent              = 0;
        cfg_writes             = 0;
        idle_cycles            = 0;
        no_gaps                = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < 25; i++)
        begin
            if (i == 0 || dir_tab[i].hevc != hevc_sel)
            begin
                drain();
                write_hevc(dir_tab[i].hevc);
            end
            w.data  = dir_tab[i].data;
            w.first = dir_tab[i].first;
            w.last  = dir_tab[i].last;
            w.len   = dir_tab[i].len;
            put_word(w, n);
            if (dir_tab[i].nres != NRES_ANY && n != int'(dir_tab[i].nres))
            begin
                fail_cnt++;
                $display("%0t: row %0d word count: expected %0d, actual %0d",
                         $time, i, dir_tab[i].nres, n);
            end
        end

        // random phases; phase 1 runs with no idling on either side
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            no_gaps = (ph == 1);
            write_hevc((ph == 2) ? 1'($urandom_range(0, 1)) : ((ph == 1) ? 1'b0 : 1'b1));
            ph_items = 0;
            while (ph_items < ITEMS_PER_PH)
                send_message(ph_items);
        end
        drain();

        $display("Sent %0d payload words in %0d random messages plus the directed table;",
                 words_in, msgs_sent);
        $display("checked %0d NAL words over %0d header-mode writes.", words_out, cfg_writes);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
